>>> src/oid_pkg.sv
// shared types and constants for the oid subidentifier decoder
package oid_pkg;

  // default width of the subidentifier accumulator
  localparam int unsigned VALUE_BITS_DEF = 32;
  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7F;
  localparam logic [7:0] INDEX_MAX = 8'hFF;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // what the back end has to do with a queue entry
  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_PAIR,
    KIND_OVF,
    KIND_TRUNC
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] index;
    logic       last;
  } tag_t;

endpackage

>>> src/oid_if.sv
// handshake channels for octets in and arcs out
interface oid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] octet;
  logic       end_of_oid;

  modport source (output valid, output octet, output end_of_oid, input ready);
  modport sink   (input valid, input octet, input end_of_oid, output ready);
endinterface

interface oid_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] arc_value;
  logic [7:0]  arc_index;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output arc_value, output arc_index, output status,
                  output last, input ready);
  modport sink   (input valid, input arc_value, input arc_index, input status,
                  input last, output ready);
endinterface

>>> src/oid_subidentifier_decoder.sv
// top level of the object identifier subidentifier decoder
//
// decodes the content octets of an encoded object identifier, one octet per
// transaction on in_i, and delivers one transaction per arc on out_o: the
// arc value, its index from zero (saturating at 255), a status and a last
// flag. the first subidentifier becomes two arcs (0, 1 or 2, then the rest).
// an overflow past VALUE_BITS gives one error result with status 1 and then
// drops octets through the end of the identifier; a final octet that still
// has its continuation bit set gives one error result with status 2. error
// results carry an all-ones value and always have last set. an octet is
// taken every cycle while the four-entry queue between the intake and the
// result side has room; the output register delivers at most one arc per
// cycle, so apart from back-pressure on out_o the only sustained slowdown
// is the second arc that each first subidentifier adds. each arc passes
// through the queue and then the output register on its way out.
module oid_subidentifier_decoder #(
  parameter int unsigned VALUE_BITS = oid_pkg::VALUE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  oid_in_if.sink    in_i,
  oid_out_if.source out_o
);

  localparam int unsigned ENTRY_W = $bits(oid_pkg::tag_t) + VALUE_BITS;

  // front to queue
  logic                  push;
  oid_pkg::tag_t         push_tag;
  logic [VALUE_BITS-1:0] push_value;

  // queue to back
  logic                  pop;
  logic                  full;
  logic                  empty;
  logic [ENTRY_W-1:0]    rd_entry;
  oid_pkg::tag_t         pop_tag;
  logic [VALUE_BITS-1:0] pop_value;

  oid_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .octet_i      (in_i.octet),
    .end_of_oid_i (in_i.end_of_oid),
    .full_i       (full),
    .push_o       (push),
    .tag_o        (push_tag),
    .value_o      (push_value)
  );

  // decouples intake from the output handshake
  oid_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (oid_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_tag, push_value}),
    .pop_i   (pop),
    .rdata_o (rd_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  assign {pop_tag, pop_value} = rd_entry;

  oid_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .tag_i       (pop_tag),
    .value_i     (pop_value),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .arc_value_o (out_o.arc_value),
    .arc_index_o (out_o.arc_index),
    .status_o    (out_o.status),
    .last_o      (out_o.last)
  );

  // the intake never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue written while full");

  // the result side never reads an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty)
    else $error("queue read while empty");

  // a first subidentifier leaves the output register with arc index 0 next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop && pop_tag.kind == oid_pkg::KIND_PAIR
                   |=> out_o.valid && out_o.arc_index == 8'd0 && !out_o.last)
    else $error("first arc of a pair not presented");

  // error results always close the identifier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop && (pop_tag.kind == oid_pkg::KIND_OVF ||
                           pop_tag.kind == oid_pkg::KIND_TRUNC)
                   |=> out_o.last && out_o.arc_value == 32'hFFFF_FFFF)
    else $error("error result without last or all-ones value");

endmodule

>>> src/oid_front.sv
// octet intake: base-128 gathering, overflow and truncation detection
module oid_front #(
  parameter int unsigned VALUE_BITS = oid_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            octet_i,
  input  logic                  end_of_oid_i,
  input  logic                  full_i,
  output logic                  push_o,
  output oid_pkg::tag_t         tag_o,
  output logic [VALUE_BITS-1:0] value_o
);

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [7:0]            count_q, count_d;
  logic                  skip_q, skip_d;
  logic                  accept;
  logic                  overflow;
  logic [VALUE_BITS-1:0] value;
  logic [7:0]            data;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign overflow   = acc_q[VALUE_BITS-1 -: 7] != 7'd0;
  assign data       = octet_i & oid_pkg::DATA_MASK;
  assign value      = {acc_q[VALUE_BITS-8:0], data[6:0]};
  assign value_o    = value;

  always_comb begin
    acc_d       = acc_q;
    count_d     = count_q;
    skip_d      = skip_q;
    push_o      = 1'b0;
    tag_o.kind  = oid_pkg::KIND_SINGLE;
    tag_o.index = count_q;
    tag_o.last  = end_of_oid_i;
    if (accept) begin
      priority if (skip_q) begin
        if (end_of_oid_i) begin
          skip_d  = 1'b0;
          count_d = 8'd0;
          acc_d   = '0;
        end
      end else if (overflow) begin
        push_o     = 1'b1;
        tag_o.kind = oid_pkg::KIND_OVF;
        tag_o.last = 1'b1;
        acc_d      = '0;
        if (end_of_oid_i) begin
          count_d = 8'd0;
        end else begin
          skip_d = 1'b1;
        end
      end else if ((octet_i & oid_pkg::CONT_BIT) != 8'd0) begin
        if (end_of_oid_i) begin
          push_o     = 1'b1;
          tag_o.kind = oid_pkg::KIND_TRUNC;
          tag_o.last = 1'b1;
          acc_d      = '0;
          count_d    = 8'd0;
        end else begin
          acc_d = value;
        end
      end else begin
        push_o = 1'b1;
        acc_d  = '0;
        if (count_q == 8'd0) begin
          tag_o.kind = oid_pkg::KIND_PAIR;
          count_d    = 8'd2;
        end else if (count_q != oid_pkg::INDEX_MAX) begin
          count_d = count_q + 8'd1;
        end
        if (end_of_oid_i) begin
          count_d = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      count_q <= 8'd0;
      skip_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      count_q <= count_d;
      skip_q  <= skip_d;
    end
  end

endmodule

>>> src/oid_queue.sv
// small fifo between the intake and the result side
module oid_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = oid_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/oid_back.sv
// result side: splits the first subidentifier and drives the output register
module oid_back #(
  parameter int unsigned VALUE_BITS = oid_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  oid_pkg::tag_t         tag_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           arc_value_o,
  output logic [7:0]            arc_index_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  logic                  valid_q;
  logic [31:0]           arc_q;
  logic [7:0]            index_q;
  logic [1:0]            status_q;
  logic                  last_q;
  logic                  pend_q;
  logic [31:0]           pend_arc_q;
  logic                  pend_last_q;
  logic                  load;
  logic [VALUE_BITS-1:0] first_arc;
  logic [VALUE_BITS-1:0] second_arc;
  logic [VALUE_BITS+31:0] ext_value;
  logic [VALUE_BITS+31:0] ext_first;
  logic [VALUE_BITS+31:0] ext_second;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  // first subidentifier: 0..39 -> arc 0, 40..79 -> arc 1, else arc 2
  always_comb begin
    if (value_i < VALUE_BITS'(40)) begin
      first_arc = VALUE_BITS'(0);
    end else if (value_i < VALUE_BITS'(80)) begin
      first_arc = VALUE_BITS'(1);
    end else begin
      first_arc = VALUE_BITS'(2);
    end
  end

  always_comb begin
    if (value_i < VALUE_BITS'(40)) begin
      second_arc = value_i;
    end else if (value_i < VALUE_BITS'(80)) begin
      second_arc = value_i - VALUE_BITS'(40);
    end else begin
      second_arc = value_i - VALUE_BITS'(80);
    end
  end

  assign ext_value  = {32'd0, value_i};
  assign ext_first  = {32'd0, first_arc};
  assign ext_second = {32'd0, second_arc};

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        arc_q    <= pend_arc_q;
        index_q  <= 8'd1;
        status_q <= oid_pkg::ST_OK;
        last_q   <= pend_last_q;
      end else if (!empty_i) begin
        unique case (tag_i.kind)
          oid_pkg::KIND_SINGLE: begin
            arc_q    <= ext_value[31:0];
            index_q  <= tag_i.index;
            status_q <= oid_pkg::ST_OK;
            last_q   <= tag_i.last;
          end
          oid_pkg::KIND_PAIR: begin
            arc_q    <= ext_first[31:0];
            index_q  <= 8'd0;
            status_q <= oid_pkg::ST_OK;
            last_q   <= 1'b0;
          end
          oid_pkg::KIND_OVF: begin
            arc_q    <= '1;
            index_q  <= tag_i.index;
            status_q <= oid_pkg::ST_OVF;
            last_q   <= tag_i.last;
          end
          oid_pkg::KIND_TRUNC: begin
            arc_q    <= '1;
            index_q  <= tag_i.index;
            status_q <= oid_pkg::ST_TRUNC;
            last_q   <= tag_i.last;
          end
          default: begin
            arc_q    <= '1;
            index_q  <= tag_i.index;
            status_q <= oid_pkg::ST_OK;
            last_q   <= tag_i.last;
          end
        endcase
      end
    end
    if (pop_o && tag_i.kind == oid_pkg::KIND_PAIR) begin
      pend_arc_q  <= ext_second[31:0];
      pend_last_q <= tag_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      valid_q <= pend_q || !empty_i;
      pend_q  <= pop_o && tag_i.kind == oid_pkg::KIND_PAIR;
    end
  end

  assign out_valid_o = valid_q;
  assign arc_value_o = arc_q;
  assign arc_index_o = index_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule
